// ===== rtl/cle_pkg.sv =====
// Shared types and constants for the circular list engine.
`default_nettype none
package cle_pkg;
   localparam int CAPACITY_DEF = 64;
   localparam int FUNC_W = 3;
   localparam int NAME_W = 64;
   localparam int COUNT_W = 16;
   localparam int SIZE_W = 7;

   typedef enum logic [2:0] {
      FN_INSERT = 3'd0,
      FN_REMOVE = 3'd1,
      FN_ADVANCE = 3'd2,
      FN_SEEK = 3'd3,
      FN_READ = 3'd4
   } func_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [NAME_W-1:0] name_key;
      logic signed [COUNT_W-1:0] count;
   } req_type;

   typedef struct packed {
      logic ok;
      logic [NAME_W-1:0] name_out;
      logic [SIZE_W-1:0] list_size;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MOD,
      ST_WALK,
      ST_RDNEXT,
      ST_INS_FREE,
      ST_INS_LINK,
      ST_REM_HEAD,
      ST_REM_LINK,
      ST_SEEK_RD,
      ST_SEEK_CMP,
      ST_READ_NAME,
      ST_DONE
   } state_type;
endpackage
`default_nettype wire

// ===== rtl/cle_if.sv =====
// Valid/ready channel interface for transactions.
`default_nettype none
interface cle_if #(parameter int W = 8) (input wire logic clock);
   logic valid;
   logic ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/cle_ram.sv =====
// Generic single-port RAM with registered read.
`default_nettype none
module cle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input wire logic clock,
   input wire logic wr_en,
   input wire logic [$clog2(DEPTH)-1:0] addr,
   input wire logic [WIDTH-1:0] wr_data,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[addr] <= wr_data;
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

// ===== rtl/cle_front.sv =====
// Front end: accepts requests into a two-entry queue.
`default_nettype none
module cle_front (
   input wire logic clock,
   input wire logic reset,
   input wire logic in_valid,
   output logic in_ready,
   input wire cle_pkg::req_type in_data,
   output logic q_valid,
   input wire logic q_pop,
   output cle_pkg::req_type q_data
);
   import cle_pkg::*;
   req_type buf_ff [2];
   logic wr_ptr_ff, rd_ptr_ff;
   logic [1:0] cnt_ff;
   logic push;
   assign in_ready = (cnt_ff != 2'd2);
   assign push = in_valid && in_ready;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_data = buf_ff[rd_ptr_ff];
   always_ff @(posedge clock) begin
      if (push) buf_ff[wr_ptr_ff] <= in_data;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (q_pop) rd_ptr_ff <= !rd_ptr_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, q_pop};
      end
   end
endmodule
`default_nettype wire

// ===== rtl/cle_back.sv =====
// Back end: walks and updates the linked list held in the next, name and free-stack RAMs.
`default_nettype none
module cle_back #(
   parameter int CAPACITY = cle_pkg::CAPACITY_DEF
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic q_valid,
   output logic q_pop,
   input wire cle_pkg::req_type q_data,
   output logic out_valid,
   input wire logic out_ready,
   output cle_pkg::rsp_type out_data
);
   import cle_pkg::*;
   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   state_type state_ff, state_in;
   req_type req_ff, req_in;
   logic [AW-1:0] cursor_ff, cursor_in;
   logic [CW-1:0] size_ff, size_in;
   logic [CW-1:0] ftop_ff, ftop_in;
   logic [CW-1:0] init_ff, init_in;
   logic [COUNT_W-1:0] steps_ff, steps_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] slot_ff, slot_in;
   logic [CW-1:0] guard_ff, guard_in;
   logic busy_ff, busy_in;
   rsp_type res_ff, res_in;
   rsp_type rsp_ff, rsp_in;
   logic vld_ff, vld_in;

   logic nx_we, nm_we, fs_we;
   logic [AW-1:0] nx_addr, nm_addr, fs_addr;
   logic [AW-1:0] nx_wd, fs_wd, nx_rd, fs_rd;
   logic [NAME_W-1:0] nm_rd;

   cle_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_next (
      .clock, .wr_en(nx_we), .addr(nx_addr), .wr_data(nx_wd), .rd_data(nx_rd));
   cle_ram #(.WIDTH(NAME_W), .DEPTH(CAPACITY)) u_name (
      .clock, .wr_en(nm_we), .addr(nm_addr), .wr_data(req_ff.name_key),
      .rd_data(nm_rd));
   cle_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_free (
      .clock, .wr_en(fs_we), .addr(fs_addr), .wr_data(fs_wd), .rd_data(fs_rd));

   logic [COUNT_W-1:0] cnt_pos;
   logic neg;
   assign neg = req_ff.count[COUNT_W-1];
   assign cnt_pos = neg ? '0 : req_ff.count;
   assign out_valid = vld_ff;
   assign out_data = rsp_ff;

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      steps_ff <= steps_in;
      ptr_ff <= ptr_in;
      head_ff <= head_in;
      slot_ff <= slot_in;
      guard_ff <= guard_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         cursor_ff <= '0;
         size_ff <= '0;
         ftop_ff <= CW'(CAPACITY);
         init_ff <= '0;
         busy_ff <= 1'b1;
         vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cursor_ff <= cursor_in;
         size_ff <= size_in;
         ftop_ff <= ftop_in;
         init_ff <= init_in;
         busy_ff <= busy_in;
         vld_ff <= vld_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      cursor_in = cursor_ff;
      size_in = size_ff;
      ftop_in = ftop_ff;
      init_in = init_ff;
      steps_in = steps_ff;
      ptr_in = ptr_ff;
      head_in = head_ff;
      slot_in = slot_ff;
      guard_in = guard_ff;
      busy_in = busy_ff;
      res_in = res_ff;
      rsp_in = rsp_ff;
      vld_in = vld_ff;
      q_pop = 1'b0;
      nx_we = 1'b0; nm_we = 1'b0; fs_we = 1'b0;
      nx_addr = ptr_ff; nm_addr = ptr_ff; fs_addr = init_ff[AW-1:0];
      nx_wd = ptr_ff; fs_wd = init_ff[AW-1:0];
      if (vld_ff && out_ready) vld_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (busy_ff) begin
               // fill the free stack with every slot after reset
               fs_we = 1'b1;
               init_in = init_ff + 1'b1;
               if (init_ff == CW'(CAPACITY - 1)) busy_in = 1'b0;
            end else if (q_valid) begin
               q_pop = 1'b1;
               req_in = q_data;
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            // load the step count and pick the next state for the function
            res_in.ok = 1'b0;
            res_in.name_out = '0;
            steps_in = cnt_pos;
            nx_addr = cursor_ff;
            ptr_in = cursor_ff;
            state_in = ST_DONE;
            if (req_ff.func == FN_INSERT) begin
               if (ftop_ff != '0 && size_ff != CW'(CAPACITY)) begin
                  fs_addr = AW'(ftop_ff - 1'b1);
                  ftop_in = ftop_ff - 1'b1;
                  state_in = ST_INS_FREE;
               end
            end else if (size_ff != '0) begin
               case (req_ff.func)
                  FN_REMOVE: state_in = ST_WALK;
                  FN_ADVANCE: if (!neg) state_in = ST_WALK;
                  FN_SEEK: state_in = ST_RDNEXT;
                  FN_READ: if (!neg && COUNT_W'(size_ff) > cnt_pos) state_in = ST_RDNEXT;
                  default: state_in = ST_DONE;
               endcase
               if (state_in == ST_WALK) state_in = ST_RDNEXT;
               guard_in = '0;
            end
         end
         ST_RDNEXT: begin
            // for remove and advance, reduce steps modulo size before walking
            nx_addr = ptr_ff;
            if ((req_ff.func == FN_REMOVE || req_ff.func == FN_ADVANCE)
                && steps_ff >= COUNT_W'(size_ff)) begin
               steps_in = steps_ff - COUNT_W'(size_ff);
            end else begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            // nx_rd holds next of ptr_ff
            nx_addr = nx_rd;
            case (req_ff.func)
               FN_REMOVE, FN_ADVANCE: begin
                  if (steps_ff != '0) begin
                     ptr_in = nx_rd;
                     steps_in = steps_ff - 1'b1;
                  end else begin
                     cursor_in = ptr_ff;
                     if (req_ff.func == FN_ADVANCE) begin
                        res_in.ok = 1'b1;
                        state_in = ST_DONE;
                     end else begin
                        head_in = nx_rd;
                        nm_addr = nx_rd;
                        state_in = ST_REM_HEAD;
                     end
                  end
               end
               FN_SEEK: begin
                  head_in = nx_rd;
                  ptr_in = nx_rd;
                  nm_addr = nx_rd;
                  state_in = ST_SEEK_CMP;
               end
               default: begin
                  if (steps_ff != '0) begin
                     ptr_in = nx_rd;
                     steps_in = steps_ff - 1'b1;
                     if (guard_ff == '0) guard_in = CW'(1);
                  end else begin
                     state_in = ST_READ_NAME;
                  end
                  if (guard_ff == '0) begin
                     // first step goes from cursor to head
                     ptr_in = nx_rd;
                     steps_in = steps_ff;
                     guard_in = CW'(1);
                     state_in = ST_WALK;
                  end
               end
            endcase
         end
         ST_READ_NAME: begin
            nm_addr = ptr_ff;
            state_in = ST_SEEK_RD;
         end
         ST_SEEK_RD: begin
            if (req_ff.func == FN_READ) begin
               res_in.ok = 1'b1;
               res_in.name_out = nm_rd;
               state_in = ST_DONE;
            end else begin
               // nm_rd and nx_rd belong to ptr_ff
               nm_addr = ptr_ff;
               nx_addr = ptr_ff;
               state_in = ST_SEEK_CMP;
            end
         end
         ST_SEEK_CMP: begin
            // nm_rd is name of ptr_ff, nx_rd is its next
            nx_addr = nx_rd;
            nm_addr = nx_rd;
            if (nm_rd == req_ff.name_key) begin
               res_in.ok = 1'b1;
               cursor_in = (ptr_ff == head_ff) ? cursor_ff : slot_ff;
               state_in = ST_DONE;
            end else if (nx_rd == head_ff || guard_ff == CW'(size_ff - 1'b1)) begin
               state_in = ST_DONE;
            end else begin
               slot_in = ptr_ff;
               ptr_in = nx_rd;
               guard_in = guard_ff + 1'b1;
            end
         end
         ST_INS_FREE: begin
            // hold the free stack read on the popped slot
            fs_addr = ftop_ff[AW-1:0];
            state_in = ST_INS_LINK;
         end
         ST_INS_LINK: begin
            // fs_rd is new slot, nx_rd is next of cursor
            nm_we = 1'b1;
            nm_addr = fs_rd;
            nx_we = 1'b1;
            nx_addr = fs_rd;
            nx_wd = (size_ff == '0) ? fs_rd : nx_rd;
            slot_in = fs_rd;
            state_in = (size_ff == '0) ? ST_DONE : ST_REM_LINK;
            cursor_in = fs_rd;
            size_in = size_ff + 1'b1;
            res_in.ok = 1'b1;
         end
         ST_REM_HEAD: begin
            // nm_rd is head name, nx_rd is next of head
            res_in.ok = 1'b1;
            res_in.name_out = nm_rd;
            if (size_ff != CW'(1)) begin
               nx_we = 1'b1;
               nx_addr = cursor_ff;
               nx_wd = nx_rd;
            end
            size_in = size_ff - 1'b1;
            if (ftop_ff != CW'(CAPACITY)) begin
               fs_we = 1'b1;
               fs_addr = ftop_ff[AW-1:0];
               fs_wd = head_ff;
               ftop_in = ftop_ff + 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_REM_LINK: begin
            // link the old cursor to the new slot
            nx_we = 1'b1;
            nx_addr = ptr_ff;
            nx_wd = slot_ff;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold the result here until the output register frees up
            if (!vld_ff || out_ready) begin
               vld_in = 1'b1;
               rsp_in = res_ff;
               rsp_in.list_size = SIZE_W'(size_ff);
               if (!res_ff.ok) rsp_in.name_out = '0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

// ===== rtl/circular_list_engine.sv =====
// Top level of the circular list engine.
// The time to a result grows with the nodes walked and with the subtracts that
// reduce a step count modulo the size.
// The back end holds one transaction at a time; the next is popped from the
// queue once the previous result is registered and the back end is idle again.
// Reset: synchronous; after it the back end fills the free stack with every slot,
// while requests only fill the two-entry queue.
`default_nettype none
module circular_list_engine #(
   parameter int CAPACITY = cle_pkg::CAPACITY_DEF
) (
   input wire logic clock,
   input wire logic reset,
   cle_if.sink req_ch,
   cle_if.source rsp_ch
);
   import cle_pkg::*;
   logic q_valid, q_pop;
   req_type q_data;
   rsp_type rsp;

   cle_front u_front (
      .clock, .reset,
      .in_valid(req_ch.valid), .in_ready(req_ch.ready), .in_data(req_ch.data),
      .q_valid, .q_pop, .q_data);

   cle_back #(.CAPACITY(CAPACITY)) u_back (
      .clock, .reset, .q_valid, .q_pop, .q_data,
      .out_valid(rsp_ch.valid), .out_ready(rsp_ch.ready), .out_data(rsp));

   assign rsp_ch.data = rsp;
endmodule
`default_nettype wire

// ===== tb/tb_circular_list_engine.sv =====
// Self-checking testbench for the circular list engine: random list operations with a predictor.
`timescale 1ns / 100ps
module tb_circular_list_engine;
   import cle_pkg::*;

   localparam int SLOTS = CAPACITY_DEF;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   cle_if #(.W($bits(req_type))) req_ch (clock);
   cle_if #(.W($bits(rsp_type))) rsp_ch (clock);

   circular_list_engine u_dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   // Predicted list state
   logic [NAME_W-1:0] list_names[SLOTS];
   logic [5:0] list_next[SLOTS];
   logic [5:0] tail_slot;
   int entries;
   logic [5:0] free_slots[SLOTS];
   int free_cnt;

   req_type pending_ops[$];
   rsp_type expected_rsp[$];
   logic [NAME_W-1:0] name_pool[12];
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_cycles = 0;
   logic hold_req = 1'b0;
   int errors = 0;
   int accepted = 0;
   int checked = 0;
   int ok_seen = 0;
   int full_hits = 0;

   function automatic void step_tail(int n);
      int k;
      k = n % entries;
      while (k > 0) begin
         tail_slot = list_next[tail_slot];
         k--;
      end
   endfunction

   function automatic rsp_type apply_op(req_type r);
      rsp_type o;
      bit neg;
      int steps;
      int guard;
      logic [5:0] s;
      logic [5:0] h;
      logic [5:0] a;
      o = '0;
      neg = r.count[COUNT_W-1];
      steps = neg ? 0 : int'(r.count);
      if (r.func == FN_INSERT) begin
         if (free_cnt > 0 && entries < SLOTS) begin
            free_cnt--;
            s = free_slots[free_cnt];
            list_names[s] = r.name_key;
            if (entries == 0) begin
               list_next[s] = s;
            end else begin
               list_next[s] = list_next[tail_slot];
               list_next[tail_slot] = s;
            end
            tail_slot = s;
            entries++;
            o.ok = 1'b1;
         end else begin
            full_hits++;
         end
      end else if (entries == 0) begin
         o.ok = 1'b0;
      end else if (r.func == FN_REMOVE) begin
         step_tail(steps);
         h = list_next[tail_slot];
         o.name_out = list_names[h];
         if (entries == 1) begin
            entries = 0;
         end else begin
            list_next[tail_slot] = list_next[h];
            entries--;
         end
         if (free_cnt < SLOTS) begin
            free_slots[free_cnt] = h;
            free_cnt++;
         end
         o.ok = 1'b1;
      end else if (r.func == FN_ADVANCE) begin
         if (!neg) begin
            step_tail(steps);
            o.ok = 1'b1;
         end
      end else if (r.func == FN_SEEK) begin
         h = list_next[tail_slot];
         if (list_names[h] == r.name_key) begin
            o.ok = 1'b1;
         end else begin
            a = h;
            guard = entries;
            while (guard > 0 && list_next[a] != h && list_names[list_next[a]] != r.name_key) begin
               a = list_next[a];
               guard--;
            end
            if (guard > 0 && list_next[a] != h) begin
               tail_slot = a;
               o.ok = 1'b1;
            end
         end
      end else if (r.func == FN_READ) begin
         if (!neg && steps < entries) begin
            a = list_next[tail_slot];
            for (int i = 0; i < steps; i++) a = list_next[a];
            o.name_out = list_names[a];
            o.ok = 1'b1;
         end
      end
      if (!o.ok) o.name_out = '0;
      o.list_size = SIZE_W'(entries);
      return o;
   endfunction

   function automatic req_type make_op(logic [2:0] f, logic [NAME_W-1:0] k, int c);
      req_type r;
      r.func = f;
      r.name_key = k;
      r.count = COUNT_W'(c);
      return r;
   endfunction

   function automatic req_type random_op(int insert_pct);
      req_type r;
      int p;
      p = $urandom_range(99);
      if (p < insert_pct) r.func = FN_INSERT;
      else if (p < 97) r.func = 3'($urandom_range(1, 4));
      else r.func = 3'($urandom_range(5, 7));
      p = $urandom_range(99);
      if (p < 50) r.name_key = name_pool[$urandom_range(11)];
      else if (p < 53) r.name_key = {NAME_W{p[0]}};
      else r.name_key = {$urandom, $urandom};
      p = $urandom_range(99);
      if (p < 60) r.count = COUNT_W'($urandom_range(0, 9));
      else if (p < 80) r.count = COUNT_W'($urandom_range(0, 70));
      else if (p < 90) r.count = COUNT_W'(-int'($urandom_range(1, 32768)));
      else if (p < 99) r.count = COUNT_W'($urandom_range(0, 200));
      else r.count = COUNT_W'($urandom_range(0, 65535));
      return r;
   endfunction

   // Driver: advance to the next transaction once the current one is taken
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_ch.data <= pending_ops.pop_front();
            req_ch.valid <= 1'b1;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Response side: random stalls plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_req) begin
         hold_req <= 1'b0;
         hold_cycles <= 400;
         rsp_ch.ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Monitor: predict on accepted requests, check accepted responses
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            expected_rsp.push_back(apply_op(req_type'(req_ch.data)));
            accepted++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_type'(rsp_ch.data);
            if (expected_rsp.size() == 0) begin
               $display("%0t: unexpected response ok=%0b name=%h size=%0d",
                        $realtime, got.ok, got.name_out, got.list_size);
               errors++;
            end else begin
               want = expected_rsp.pop_front();
               checked++;
               if (got.ok) ok_seen++;
               if (got.ok !== want.ok || got.name_out !== want.name_out ||
                   got.list_size !== want.list_size) begin
                  $display("%0t: mismatch expected ok=%0b name=%h size=%0d actual ok=%0b name=%h size=%0d",
                           $realtime, want.ok, want.name_out, want.list_size,
                           got.ok, got.name_out, got.list_size);
                  errors++;
               end
            end
         end
      end
   end

   task automatic drain();
      while (pending_ops.size() > 0 || req_ch.valid || expected_rsp.size() > 0)
         @(posedge clock);
   endtask

   task automatic run_random(int n, int idle, int stall);
      send_idle_pct = idle;
      stall_pct = stall;
      for (int i = 0; i < n; i++)
         pending_ops.push_back(random_op(((i / 60) % 2 == 0) ? 70 : 25));
      drain();
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      rsp_ch.ready = 1'b0;
      for (int i = 0; i < SLOTS; i++) free_slots[i] = 6'(i);
      free_cnt = SLOTS;
      tail_slot = '0;
      entries = 0;
      for (int i = 0; i < 12; i++) name_pool[i] = {$urandom, $urandom};
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Empty-list behavior, extremes, and each operation
      pending_ops.push_back(make_op(FN_REMOVE, '0, 0));
      pending_ops.push_back(make_op(FN_ADVANCE, '0, 1));
      pending_ops.push_back(make_op(FN_SEEK, '0, 0));
      pending_ops.push_back(make_op(FN_READ, '0, 0));
      pending_ops.push_back(make_op(3'd7, '1, -1));
      pending_ops.push_back(make_op(FN_INSERT, '1, 0));
      pending_ops.push_back(make_op(FN_REMOVE, '0, -32768));
      pending_ops.push_back(make_op(FN_INSERT, '0, 0));
      pending_ops.push_back(make_op(FN_INSERT, name_pool[0], 0));
      pending_ops.push_back(make_op(FN_INSERT, name_pool[1], 0));
      pending_ops.push_back(make_op(FN_INSERT, name_pool[0], 0));
      pending_ops.push_back(make_op(FN_READ, '0, 0));
      pending_ops.push_back(make_op(FN_READ, '0, 3));
      pending_ops.push_back(make_op(FN_READ, '0, 4));
      pending_ops.push_back(make_op(FN_READ, '0, -1));
      pending_ops.push_back(make_op(FN_ADVANCE, '0, -5));
      pending_ops.push_back(make_op(FN_ADVANCE, '0, 32767));
      pending_ops.push_back(make_op(FN_SEEK, name_pool[1], 0));
      pending_ops.push_back(make_op(FN_SEEK, name_pool[0], 0));
      pending_ops.push_back(make_op(FN_SEEK, name_pool[5], 0));
      pending_ops.push_back(make_op(FN_REMOVE, '0, 6));
      pending_ops.push_back(make_op(3'd5, '0, 0));
      pending_ops.push_back(make_op(FN_REMOVE, '0, 1));
      drain();

      // Fill the pool past capacity, then empty it
      for (int i = 0; i < SLOTS + 3; i++)
         pending_ops.push_back(make_op(FN_INSERT, {$urandom, $urandom}, 0));
      for (int i = 0; i < SLOTS + 2; i++)
         pending_ops.push_back(make_op(FN_REMOVE, '0, $urandom_range(0, 3)));
      drain();

      run_random(400, 0, 0);
      run_random(400, 81, 0);
      run_random(400, 0, 81);
      run_random(350, 21, 21);

      // Hold off the response side while requests keep coming
      send_idle_pct = 0;
      stall_pct = 0;
      hold_req = 1'b1;
      for (int i = 0; i < 100; i++) pending_ops.push_back(random_op(50));
      drain();

      repeat (200) @(posedge clock);
      if (expected_rsp.size() != 0) begin
         $display("%0t: %0d responses never arrived", $realtime, expected_rsp.size());
         errors++;
      end
      $display("Ran %0d operations, checked %0d responses (%0d succeeded, %0d inserts on a full pool).",
               accepted, checked, ok_seen, full_hits);
      $display("Phases: directed, fill and drain, random under four idle mixes, long response hold-off.");
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #300_000_000;
      $display("TEST FAILED");
      $finish;
   end
endmodule
